// ===== src/fuq_pkg.sv =====
package fuq_pkg;

   // Field widths fixed by the item format.
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   // Operation codes carried in the cmd field.
   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } cmd_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_ENQ   = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_DEQ   = 3'd3,
      ST_UNDER = 3'd4
   } status_type;

   // One stored key/data pair.
   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] payload;
   } entry_type;

   // Per-cycle command that every cell of the chain sees.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

// ===== src/fuq_channels.sv =====
interface fuq_req_if import fuq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [KEY_W-1:0]  key;
   logic signed [DATA_W-1:0] payload;

   modport source (output valid, cmd, key, payload, input ready);
   modport sink   (input valid, cmd, key, payload, output ready);
endinterface

interface fuq_rsp_if import fuq_pkg::*; #(
   parameter int OCC_W = 5
) ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [KEY_W-1:0]  out_key;
   logic signed [DATA_W-1:0] out_payload;
   logic                     is_empty;
   logic [OCC_W-1:0]         occupancy;
   logic signed [DATA_W-1:0] front_payload;
   logic signed [DATA_W-1:0] rear_payload;

   modport source (output valid, status, out_key, out_payload, is_empty, occupancy,
                   front_payload, rear_payload, input ready);
   modport sink   (input valid, status, out_key, out_payload, is_empty, occupancy,
                   front_payload, rear_payload, output ready);
endinterface

// ===== src/fifo_unique_key_queue.sv =====
// Bounded FIFO of key/data pairs that refuses a key already held in the queue.
// Operations arrive on req_if (cmd, key, payload); each one produces exactly one
// result on rsp_if with a status code, the dequeued pair, the empty flag, the
// occupancy and the data at the front and the rear after the operation.
// Storage is a chain of DEPTH cells with the oldest pair in the first cell. An
// enqueue fills the first free cell; a dequeue shifts every cell one place
// toward the front. Every cell compares its key against the incoming key in
// parallel. The result is registered at the edge that accepts the operation.
// Throughput is one operation per cycle while rsp_if is taken.
// When the receiver stalls, the finished result waits in the output register
// and req_if.ready drops until it is taken; the output register alone sets this.
// Reset (synchronous, active high) empties the queue and drops rsp_if.valid.
module fifo_unique_key_queue import fuq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   fuq_req_if.sink   req_if,
   fuq_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [DATA_W-1:0] rear_ff;

   logic [DEPTH-1:0] cell_valid;
   logic [DEPTH-1:0] cell_match;
   entry_type        cell_entry [DEPTH];
   entry_type        new_entry;
   cell_ctl_type     ctl;

   logic       accept;
   logic       dup, full, empty;
   status_type status;

   logic                     rsp_valid_ff;
   status_type               status_ff;
   logic signed [KEY_W-1:0]  out_key_ff;
   logic signed [DATA_W-1:0] out_payload_ff;
   logic                     is_empty_ff;
   logic [CNT_W-1:0]         occ_ff;
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] rear_out_ff, rear_out_in;

   // A new operation is taken whenever the output register is free or being drained.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign new_entry.key     = req_if.key;
   assign new_entry.payload = req_if.payload;

   assign dup   = |cell_match;
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Decode the operation; the duplicate check wins over the full check.
   always_comb begin
      ctl.push = 1'b0;
      ctl.pop  = 1'b0;
      if (cmd_type'(req_if.cmd) == CMD_ENQ) begin
         if (dup) begin
            status = ST_DUP;
         end else if (full) begin
            status = ST_FULL;
         end else begin
            status   = ST_ENQ;
            ctl.push = accept;
         end
      end else begin
         if (empty) begin
            status = ST_UNDER;
         end else begin
            status  = ST_DEQ;
            ctl.pop = accept;
         end
      end
   end

   // Row of storage cells; the first cell sees a filled neighbor, the last an empty one.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      prev_v;
      logic      next_v;
      entry_type next_e;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_v = 1'b0;
         assign next_e = '0;
      end else begin : g_inner
         assign next_v = cell_valid[i+1];
         assign next_e = cell_entry[i+1];
      end

      fuq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_entry (next_e),
         .new_entry  (new_entry),
         .valid      (cell_valid[i]),
         .entry      (cell_entry[i]),
         .match      (cell_match[i])
      );
   end

   // Occupancy after the operation.
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Front and rear data after the operation, zero when the queue ends up empty.
   always_comb begin
      front_in    = cell_entry[0].payload;
      rear_out_in = rear_ff;
      if (ctl.pop) begin
         front_in = cell_entry[1].payload;
      end else if (ctl.push) begin
         rear_out_in = req_if.payload;
         if (empty) begin
            front_in = req_if.payload;
         end
      end
      if (count_in == '0) begin
         front_in    = '0;
         rear_out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The newest pair's data is tracked beside the chain.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         rear_ff <= req_if.payload;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status;
         out_key_ff     <= ctl.pop ? cell_entry[0].key : '0;
         out_payload_ff <= ctl.pop ? cell_entry[0].payload : '0;
         is_empty_ff    <= (count_in == '0);
         occ_ff         <= count_in;
         front_ff       <= front_in;
         rear_out_ff    <= rear_out_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.out_key       = out_key_ff;
   assign rsp_if.out_payload   = out_payload_ff;
   assign rsp_if.is_empty      = is_empty_ff;
   assign rsp_if.occupancy     = occ_ff;
   assign rsp_if.front_payload = front_ff;
   assign rsp_if.rear_payload  = rear_out_ff;

endmodule

// ===== src/fuq_cell.sv =====
module fuq_cell import fuq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  logic                    prev_valid,
   input  logic                    next_valid,
   input  entry_type               next_entry,
   input  entry_type               new_entry,
   output logic                    valid,
   output entry_type               entry,
   output logic                    match
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      take_new;

   // This cell is the first free slot when it is empty and its older neighbor is filled.
   assign take_new = ctl.push && !valid_ff && prev_valid;

   // On a pop the whole chain shifts one place toward the front.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctl.pop) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (take_new) begin
         valid_in = 1'b1;
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Only an occupied cell takes part in the duplicate-key check.
   assign match = valid_ff && (entry_ff.key == new_entry.key);
   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule
